[rtl/core/ssop_pkg.sv]
// Shared types and constants for the two-set store with set operations.
// No dependencies; every other file in rtl/core except ssop_ram imports this package.
package ssop_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 32;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_UNION     = 2'd1,
    KIND_INTERSECT = 2'd2,
    KIND_DIFF      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch a new item, clear walk state
    logic scan_start;  // restart the inner scan
    logic scan_step;   // advance the inner scan one entry
    logic cand_ld;     // latch the outer member as candidate
    logic take;        // candidate joins the result stream
    logic i_inc;       // next outer entry
    logic phase2;      // union: switch from copying A to walking B
    logic fin;         // final beat of a set operation
    logic ins_fin;     // commit insert and send its beat
  } ssop_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  i_end;
    logic  scan_done;
    logic  hit;
    logic  pend_vld;
    logic  out_free;
    logic  ph1;
  } ssop_st_t;

endpackage

[rtl/core/ssop_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ssop_dp.sv]
// Datapath: both set stores, counts, walk indices, candidate, pending beat
// and output register. Depends on ssop_pkg and ssop_ram.
module ssop_dp
  import ssop_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_kind,
  input  logic                    in_which_set,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_ready,
  input  ssop_cmd_t               cmd,
  output ssop_st_t                st,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_member_out,
  output logic                    out_last,
  output logic                    out_a_empty,
  output logic                    out_b_empty
);

  kind_t             kind_r;
  logic              sel_r;
  logic              o_is_b_r;   // scanned store is B (outer store is A)
  logic [CNT_W-1:0]  a_cnt_r, a_cnt_nxt;
  logic [CNT_W-1:0]  b_cnt_r, b_cnt_nxt;
  logic [CNT_W-1:0]  i_r, j_r;
  logic              hit_r, rd_vld_r;
  logic              pend_vld_r;
  logic [N_W-1:0]    n_r;
  logic [VAL_W-1:0]  cand_r, pend_r;
  logic              out_valid_r, out_last_r, out_a_empty_r, out_b_empty_r;
  status_t           out_status_r;
  logic [VAL_W-1:0]  out_member_r;

  logic [VAL_W-1:0]  rd_a, rd_b, rd_m, rd_o;
  logic [CNT_W-1:0]  mc, oc, tgt_cnt;
  logic              we_a, we_b, tgt_full, ins_ok, n_full, take_ok, push, out_free;
  status_t           ins_status;

  assign rd_m = o_is_b_r ? rd_a : rd_b;
  assign rd_o = o_is_b_r ? rd_b : rd_a;
  assign mc   = o_is_b_r ? a_cnt_r : b_cnt_r;
  assign oc   = o_is_b_r ? b_cnt_r : a_cnt_r;

  assign tgt_cnt  = sel_r ? b_cnt_r : a_cnt_r;
  assign tgt_full = (tgt_cnt >= CNT_W'(CAPACITY));
  assign ins_ok   = !hit_r && !tgt_full;
  assign we_a     = cmd.ins_fin && ins_ok && !sel_r;
  assign we_b     = cmd.ins_fin && ins_ok && sel_r;

  always_comb begin
    if (hit_r) begin
      ins_status = ST_DUP;
    end else if (tgt_full) begin
      ins_status = ST_FULL;
    end else begin
      ins_status = ST_OK;
    end
  end

  always_comb begin
    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    if (we_a) begin
      a_cnt_nxt = a_cnt_r + CNT_W'(1);
    end
    if (we_b) begin
      b_cnt_nxt = b_cnt_r + CNT_W'(1);
    end
  end

  // stream is cut once MAX_RESULTS members are held
  assign n_full   = (n_r == N_W'(MAX_RESULTS));
  assign take_ok  = cmd.take && !n_full;
  assign out_free = !out_valid_r || out_ready;
  assign push     = (take_ok && pend_vld_r) || cmd.fin || cmd.ins_fin;

  ssop_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (a_cnt_r[ADDR_W-1:0]),
    .wdata (cand_r),
    .raddr (o_is_b_r ? i_r[ADDR_W-1:0] : j_r[ADDR_W-1:0]),
    .rdata (rd_a)
  );

  ssop_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (b_cnt_r[ADDR_W-1:0]),
    .wdata (cand_r),
    .raddr (o_is_b_r ? j_r[ADDR_W-1:0] : i_r[ADDR_W-1:0]),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_INSERT;
      sel_r       <= 1'b0;
      o_is_b_r    <= 1'b0;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      hit_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
      if (cmd.load) begin
        kind_r <= kind_t'(in_kind);
        sel_r  <= in_which_set;
        case (kind_t'(in_kind))
          KIND_INSERT: o_is_b_r <= in_which_set;
          KIND_DIFF:   o_is_b_r <= !in_which_set;
          default:     o_is_b_r <= 1'b1;
        endcase
      end else if (cmd.phase2) begin
        o_is_b_r <= 1'b0;
      end

      if (cmd.load || cmd.phase2) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + CNT_W'(1);
      end

      if (cmd.load || cmd.scan_start) begin
        j_r      <= '0;
        hit_r    <= 1'b0;
        rd_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (j_r < oc) begin
          j_r      <= j_r + CNT_W'(1);
          rd_vld_r <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
        if (rd_vld_r && (rd_o == cand_r)) begin
          hit_r <= 1'b1;
        end
      end

      if (cmd.load) begin
        pend_vld_r <= 1'b0;
        n_r        <= '0;
      end else if (take_ok) begin
        pend_vld_r <= 1'b1;
        n_r        <= n_r + N_W'(1);
      end

      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r <= in_value;
    end else if (cmd.cand_ld) begin
      cand_r <= rd_m;
    end
    if (take_ok) begin
      pend_r <= cand_r;
    end
    if (push) begin
      out_a_empty_r <= (a_cnt_nxt == '0);
      out_b_empty_r <= (b_cnt_nxt == '0);
      if (cmd.ins_fin) begin
        out_status_r <= ins_status;
        out_member_r <= cand_r;
        out_last_r   <= 1'b1;
      end else if (cmd.fin) begin
        out_status_r <= pend_vld_r ? ST_OK : ST_EMPTY;
        out_member_r <= pend_vld_r ? pend_r : '0;
        out_last_r   <= 1'b1;
      end else begin
        out_status_r <= ST_OK;
        out_member_r <= pend_r;
        out_last_r   <= 1'b0;
      end
    end
  end

  always_comb begin
    st.kind      = kind_r;
    st.i_end     = (i_r >= mc);
    st.scan_done = (j_r >= oc) && !rd_vld_r;
    st.hit       = hit_r;
    st.pend_vld  = pend_vld_r;
    st.out_free  = out_free;
    st.ph1       = (kind_r == KIND_UNION) && o_is_b_r;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_member_out = out_member_r;
  assign out_last       = out_last_r;
  assign out_a_empty    = out_a_empty_r;
  assign out_b_empty    = out_b_empty_r;

endmodule

[rtl/core/ssop_ctrl.sv]
// Sequencer for insert scans and the nested walks of the set operations.
// Depends on ssop_pkg; drives the datapath through ssop_cmd_t.
module ssop_ctrl
  import ssop_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_kind,
  output logic      in_ready,
  input  ssop_st_t  st,
  output ssop_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN     = 9'b000000010,
    S_OUT_RD   = 9'b000000100,
    S_OUT_LAT  = 9'b000001000,
    S_COPY_RD  = 9'b000010000,
    S_COPY_LAT = 9'b000100000,
    S_PUSH     = 9'b001000000,
    S_FIN      = 9'b010000000,
    S_INS_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   emit;

  // intersection keeps hits; difference and union's second pass keep misses
  assign emit = (st.kind == KIND_INTERSECT) ? st.hit : !st.hit;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (kind_t'(in_kind))
            KIND_INSERT: state_nxt = S_SCAN;
            KIND_UNION:  state_nxt = S_COPY_RD;
            default:     state_nxt = S_OUT_RD;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          if (st.kind == KIND_INSERT) begin
            state_nxt = S_INS_OUT;
          end else if (emit) begin
            state_nxt = S_PUSH;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_OUT_RD: begin
        state_nxt = st.i_end ? S_FIN : S_OUT_LAT;
      end
      S_OUT_LAT: begin
        cmd.cand_ld    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_COPY_RD: begin
        if (st.i_end) begin
          cmd.phase2 = 1'b1;
          state_nxt  = S_OUT_RD;
        end else begin
          state_nxt = S_COPY_LAT;
        end
      end
      S_COPY_LAT: begin
        cmd.cand_ld = 1'b1;
        state_nxt   = S_PUSH;
      end
      S_PUSH: begin
        // a held member leaves as a non-final beat when the candidate arrives
        if (!st.pend_vld || st.out_free) begin
          cmd.take  = 1'b1;
          cmd.i_inc = 1'b1;
          state_nxt = st.ph1 ? S_COPY_RD : S_OUT_RD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_OUT: begin
        if (st.out_free) begin
          cmd.ins_fin = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/two_set_store_with_set_ops_top.sv]
// Top level of the two-set store: sequencer plus datapath.
// Depends on ssop_pkg, ssop_ctrl, ssop_dp (and ssop_ram below it).
//
// Usage: one input beat per command (insert, union, intersection, difference)
// on in_* with valid/ready; result beats leave on out_* with valid/ready, the
// final beat of each command flagged by out_last.
// Items are handled one at a time; in_ready is high only while idle.
// Insert: scans the target store once, then sends its one beat.
// Set operations: for each outer member the other store is scanned, and a
//   kept member passes through S_PUSH; union first copies A. Worst case is
//   a union of two disjoint full sets.
//   Members are delayed one step so the final one can carry out_last; an
//   empty result gives one beat with status empty.
// The output register lets the last beat wait while the next command enters.
// A stalled receiver holds the walk at the next beat to send.
// Reset (rst_n low, synchronous) empties both sets and drops any pending beat;
// store contents are not cleared and need no clearing pass.
module two_set_store_with_set_ops_top
  import ssop_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic                    in_which_set,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_member_out,
  output logic                    out_last,
  output logic                    out_a_empty,
  output logic                    out_b_empty
);

  ssop_cmd_t cmd;
  ssop_st_t  st;

  ssop_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ssop_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_which_set   (in_which_set),
    .in_value       (in_value),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_member_out (out_member_out),
    .out_last       (out_last),
    .out_a_empty    (out_a_empty),
    .out_b_empty    (out_b_empty)
  );

endmodule

[rtl/core/ssop_chk.sv]
// Port-level checks for two_set_store_with_set_ops_top, bound to the top.
// Depends on ssop_pkg.
module ssop_chk
  import ssop_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              out_status,
  input logic signed [VAL_W-1:0] out_member_out,
  input logic                    out_last,
  input logic                    out_a_empty,
  input logic                    out_b_empty
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_member_out) &&
                                   $stable(out_status) && $stable(out_last)))
    else $error("result beat changed while stalled");

  // one item at a time: ready drops after an accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // with both sets empty nothing can be inserted-ok, duplicate or full
  a_both_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_a_empty && out_b_empty) |-> (out_status == ST_EMPTY))
    else $error("non-empty status while both sets empty");

  // reset drops any result beat
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("output valid after reset");

endmodule

bind two_set_store_with_set_ops_top ssop_chk u_ssop_chk (.*);

[verif/tb_two_set_store_with_set_ops_top.sv]
// Testbench for two_set_store_with_set_ops_top: a directed command table, then random commands.
// Every result beat is checked against a bench-side model of sets A and B. Depends on ssop_pkg.
module tb_two_set_store_with_set_ops_top;
  import ssop_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 305;
  localparam int POOL_N      = 24;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] member;
    logic             last;
    logic             a_empty;
    logic             b_empty;
  } beat_t;

  // typed = 1: the single beat is written out below instead of coming from the model
  typedef struct packed {
    kind_t            kind;
    logic             sel;
    logic [VAL_W-1:0] value;
    logic [4:0]       rep;
    logic             typed;
    status_t          status;
    logic [VAL_W-1:0] member;
    logic             a_empty;
    logic             b_empty;
  } cmd_row_t;

  localparam cmd_row_t DIR_ROWS [13] = '{
    '{KIND_UNION,     1'b0, 32'h0,         5'd1,  1'b1, ST_EMPTY, 32'h0,         1'b1, 1'b1},
    '{KIND_DIFF,      1'b1, 32'h0,         5'd1,  1'b1, ST_EMPTY, 32'h0,         1'b1, 1'b1},
    '{KIND_INSERT,    1'b0, 32'h8000_0000, 5'd1,  1'b1, ST_OK,    32'h8000_0000, 1'b0, 1'b1},
    '{KIND_INSERT,    1'b0, 32'h7fff_ffff, 5'd1,  1'b1, ST_OK,    32'h7fff_ffff, 1'b0, 1'b1},
    '{KIND_INSERT,    1'b1, 32'hffff_ffff, 5'd1,  1'b1, ST_OK,    32'hffff_ffff, 1'b0, 1'b0},
    '{KIND_INSERT,    1'b1, 32'h7fff_ffff, 5'd1,  1'b1, ST_OK,    32'h7fff_ffff, 1'b0, 1'b0},
    '{KIND_INSERT,    1'b1, 32'hffff_ffff, 5'd1,  1'b1, ST_DUP,   32'hffff_ffff, 1'b0, 1'b0},
    '{KIND_INTERSECT, 1'b0, 32'h0,         5'd1,  1'b0, ST_OK,    32'h0,         1'b0, 1'b0},
    // fill A up to capacity with 1..14
    '{KIND_INSERT,    1'b0, 32'h1,         5'd14, 1'b0, ST_OK,    32'h0,         1'b0, 1'b0},
    '{KIND_INSERT,    1'b0, 32'd100,       5'd1,  1'b1, ST_FULL,  32'd100,       1'b0, 1'b0},
    // duplicate into a full set reports duplicate, not full
    '{KIND_INSERT,    1'b0, 32'h8000_0000, 5'd1,  1'b1, ST_DUP,   32'h8000_0000, 1'b0, 1'b0},
    '{KIND_UNION,     1'b1, 32'hffff_ffff, 5'd1,  1'b0, ST_OK,    32'h0,         1'b0, 1'b0},
    '{KIND_DIFF,      1'b0, 32'h0,         5'd1,  1'b0, ST_OK,    32'h0,         1'b0, 1'b0}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_kind = KIND_INSERT;
  logic                    in_which_set = 1'b0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_member_out;
  logic                    out_last;
  logic                    out_a_empty;
  logic                    out_b_empty;

  logic [VAL_W-1:0] set_a [CAPACITY];
  logic [VAL_W-1:0] set_b [CAPACITY];
  int               cnt_a = 0;
  int               cnt_b = 0;
  beat_t            expected_beats [$];
  logic [VAL_W-1:0] value_pool [POOL_N];
  bit               quiet = 1'b0;
  int               errors = 0;
  int               idle_cycles = 0;

  two_set_store_with_set_ops_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_which_set(in_which_set), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_member_out(out_member_out), .out_last(out_last),
    .out_a_empty(out_a_empty), .out_b_empty(out_b_empty)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 16);
  end

  function automatic bit is_member(bit in_b, logic [VAL_W-1:0] v);
    int i;
    for (i = 0; i < (in_b ? cnt_b : cnt_a); i++)
      if ((in_b ? set_b[i] : set_a[i]) == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_beat(status_t s, logic [VAL_W-1:0] m, logic l);
    expected_beats.push_back('{s, m, l, (cnt_a == 0), (cnt_b == 0)});
  endfunction

  // updates the sets and queues the beats one command produces
  function automatic void apply_command(kind_t k, logic sel, logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] members [$];
    logic [VAL_W-1:0] m;
    status_t          s;
    int               i;
    if (k == KIND_INSERT) begin
      if (is_member(sel, v)) s = ST_DUP;
      else if ((sel ? cnt_b : cnt_a) >= CAPACITY) s = ST_FULL;
      else begin
        s = ST_OK;
        if (sel) begin
          set_b[cnt_b] = v;
          cnt_b++;
        end else begin
          set_a[cnt_a] = v;
          cnt_a++;
        end
      end
      push_beat(s, v, 1'b1);
      return;
    end
    case (k)
      KIND_UNION: begin
        for (i = 0; i < cnt_a; i++) members.push_back(set_a[i]);
        for (i = 0; i < cnt_b; i++)
          if (!is_member(1'b0, set_b[i])) members.push_back(set_b[i]);
      end
      KIND_INTERSECT: begin
        for (i = 0; i < cnt_a; i++)
          if (is_member(1'b1, set_a[i])) members.push_back(set_a[i]);
      end
      default: begin
        for (i = 0; i < (sel ? cnt_b : cnt_a); i++) begin
          m = sel ? set_b[i] : set_a[i];
          if (!is_member(!sel, m)) members.push_back(m);
        end
      end
    endcase
    if (members.size() == 0) push_beat(ST_EMPTY, '0, 1'b1);
    else begin
      while (members.size() > MAX_RESULTS) void'(members.pop_back());
      for (i = 0; i < members.size(); i++)
        push_beat(ST_OK, members[i], i == members.size() - 1);
    end
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_command(kind_t k, logic sel, logic [VAL_W-1:0] v);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_which_set <= sel;
    in_value     <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(k, sel, v);
  endtask

  initial begin
    cmd_row_t         row;
    kind_t            k;
    logic [VAL_W-1:0] v;
    int               i;
    int               j;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0;
    value_pool[3] = 32'hffff_ffff;
    // small values overlap what the directed part left in A
    for (i = 4; i < 10; i++) value_pool[i] = i - 3;
    for (i = 10; i < POOL_N; i++) value_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(DIR_ROWS); i++) begin
      row = DIR_ROWS[i];
      for (j = 0; j < row.rep; j++) begin
        send_command(row.kind, row.sel, row.value + j);
        if (row.typed) begin
          void'(expected_beats.pop_back());
          expected_beats.push_back('{row.status, row.member, 1'b1, row.a_empty, row.b_empty});
        end
      end
    end

    for (i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= 100 && i < 160);
      k = ($urandom_range(99) < 55) ? KIND_INSERT : kind_t'($urandom_range(1, 3));
      v = ($urandom_range(99) < 80) ? value_pool[$urandom_range(POOL_N - 1)] : $urandom;
      send_command(k, 1'($urandom_range(1)), v);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb_two_set_store_with_set_ops_top OK");
    end else begin
      $display("tb_two_set_store_with_set_ops_top NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin : check_beats
    beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: st=%0d mem=%h last=%b", out_status, out_member_out,
                   out_last);
      end else begin
        want = expected_beats.pop_front();
        if (out_status !== want.status || out_member_out !== want.member ||
            out_last !== want.last || out_a_empty !== want.a_empty ||
            out_b_empty !== want.b_empty) begin
          errors++;
          if (errors <= 10)
            $display({"beat mismatch: want st=%0d mem=%h last=%b ae=%b be=%b,",
                      " got st=%0d mem=%h last=%b ae=%b be=%b"},
                     want.status, want.member, want.last, want.a_empty, want.b_empty,
                     out_status, out_member_out, out_last, out_a_empty, out_b_empty);
        end
      end
    end
  end

  // no beat moving on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_two_set_store_with_set_ops_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
